// File: rtl/core/knap_pkg.sv
package knap_pkg;

  localparam int MAX_CAPACITY_DEF = 1023;
  localparam int SUM_WIDTH_DEF    = 32;

  localparam int WEIGHT_W = 10;
  localparam int VALUE_W  = 16;
  localparam int CAP_W    = 10;
  localparam int OUT_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } knap_state_t;

  // clamp a row entry to the 32-bit result range
  function automatic logic [OUT_W-1:0] sat_out(input logic [63:0] v);
    logic [OUT_W-1:0] r;
    if (v > 64'h0000_0000_FFFF_FFFF) begin
      r = '1;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/knap_row_ram.sv
module knap_row_ram
  import knap_pkg::*;
#(
  parameter int DEPTH  = MAX_CAPACITY_DEF + 1,
  parameter int WIDTH  = SUM_WIDTH_DEF,
  parameter int ADDR_W = $clog2(MAX_CAPACITY_DEF + 1)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_a_addr,
  input  logic [ADDR_W-1:0] rd_b_addr,
  output logic [WIDTH-1:0]  rd_a_data,
  output logic [WIDTH-1:0]  rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

// File: rtl/core/zero_one_knapsack_best_value_top.sv
// 0/1 knapsack best-value engine. Each request (weight, value, last flag) is
// accepted when start is high and busy is low, and then sweeps the row of
// best values from MAX_CAPACITY down to 1 with one read-modify-write per
// cycle through a single saturating add/compare unit fed by a two-read,
// one-write row RAM. On a request flagged last, out_valid pulses for one
// cycle, the first cycle with busy low again, with out_best_value holding the
// best value at the configured capacity (capacity above the row reads the top
// entry); the same sweep writes the row back to zero. The receiver cannot
// stall the result, so it must take it in that cycle. After reset, busy stays
// high while the row RAM is cleared. The capacity register is written through
// cfg_valid/cfg_ready and should only change while idle.
module zero_one_knapsack_best_value_top
  import knap_pkg::*;
#(
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [WEIGHT_W-1:0] in_item_weight,
  input  logic [VALUE_W-1:0]  in_item_value,
  input  logic                in_last_item,
  output logic                out_valid,
  output logic [OUT_W-1:0]    out_best_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_capacity
);

  localparam int DEPTH  = MAX_CAPACITY + 1;
  localparam int ADDR_W = $clog2(MAX_CAPACITY + 1);
  localparam int CW0    = (ADDR_W > WEIGHT_W) ? ADDR_W : WEIGHT_W;
  localparam int CW     = (CW0 > CAP_W) ? CW0 : CAP_W;
  localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(MAX_CAPACITY);

  knap_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]    c_r, c_nxt;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [VALUE_W-1:0]   value_r;
  logic                 last_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [CAP_W-1:0]     capacity_r;
  logic                 s2_valid_r;
  logic [ADDR_W-1:0]    s2_addr_r;
  logic                 s2_take_r;
  logic [SUM_WIDTH-1:0] result_r;

  logic                 accept;
  logic [CW-1:0]        c_ext;
  logic [CW-1:0]        w_ext;
  logic [CW-1:0]        diff;
  logic                 take;
  logic [ADDR_W-1:0]    rd_b_addr;
  logic [CW-1:0]        cap_ext;
  logic [ADDR_W-1:0]    pick;
  logic [SUM_WIDTH-1:0] rd_a_data;
  logic [SUM_WIDTH-1:0] rd_b_data;
  logic [SUM_WIDTH:0]   sum;
  logic [SUM_WIDTH-1:0] cand;
  logic [SUM_WIDTH-1:0] upd;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [SUM_WIDTH-1:0] wr_data;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // read addresses for this capacity and for capacity less weight
  assign c_ext     = CW'(c_r);
  assign w_ext     = CW'(weight_r);
  assign take      = (w_ext <= c_ext);
  assign diff      = c_ext - w_ext;
  assign rd_b_addr = take ? diff[ADDR_W-1:0] : c_r;

  assign cap_ext = CW'(capacity_r);
  assign pick    = (cap_ext > CW'(MAX_CAPACITY)) ? TOP_ADDR : cap_ext[ADDR_W-1:0];

  // saturating add and keep the larger
  assign sum  = {1'b0, rd_b_data} + (SUM_WIDTH + 1)'(value_r);
  assign cand = sum[SUM_WIDTH] ? '1 : sum[SUM_WIDTH-1:0];
  assign upd  = (s2_take_r && (cand > rd_a_data)) ? cand : rd_a_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_addr_r;
    wr_data = last_r ? '0 : upd;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = c_r;
      wr_data = '0;
    end else if (s2_valid_r) begin
      wr_en = 1'b1;
    end
  end

  knap_row_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (SUM_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_row_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (c_r),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      c_r         <= TOP_ADDR;
      out_valid_r <= 1'b0;
      s2_valid_r  <= 1'b0;
      capacity_r  <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
      s2_valid_r  <= (state_r == ST_RUN);
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r <= c_r;
    s2_take_r <= take;
    if (accept) begin
      weight_r <= in_item_weight;
      value_r  <= in_item_value;
      last_r   <= in_last_item;
      result_r <= '0;
    end else if (s2_valid_r && (s2_addr_r == pick)) begin
      result_r <= upd;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (c_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          c_nxt = c_r - 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          c_nxt     = TOP_ADDR;
        end
      end
      ST_RUN: begin
        if (c_r == ADDR_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          c_nxt = c_r - 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = last_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_best_value = sat_out(64'(result_r));

`ifndef ASSERT_OFF
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_DRAIN))
    else $error("result strobe without finished sweep");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && c_r == TOP_ADDR))
    else $error("request accepted but sweep not started at top");

  a_entry_zero_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_addr_r != '0))
    else $error("sweep wrote entry zero");

  a_no_request_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("sweep left early");
`endif

endmodule
